// File: src/taabb_pkg.sv
// shared types, constants and command codes for the transformed aabb distance query
// no dependencies
`timescale 1ns / 1ps

package taabb_pkg;

   localparam int COORD_W   = 16;
   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = 2;
   localparam int SQ_W      = 2 * COORD_W;
   localparam int DIST_W    = 34;
   localparam int ACC_W     = 34;
   localparam int FRAC_SHIFT = 12;
   localparam int TRANS_SHIFT = 8;
   localparam int Q_W       = ACC_W - FRAC_SHIFT;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_VERTEX = 2'd1,
      CMD_QUERY  = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_X = 2'd0,
      CSR_ROW_Y = 2'd1,
      CSR_ROW_Z = 2'd2
   } csr_index_type;

   localparam logic [CSR_W-1:0] ROW_X_RESET = 64'h0000_0000_0000_1000;
   localparam logic [CSR_W-1:0] ROW_Y_RESET = 64'h0000_0000_1000_0000;
   localparam logic [CSR_W-1:0] ROW_Z_RESET = 64'h0000_1000_0000_0000;

   localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7fff;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;

   localparam logic signed [ACC_W-1:0] ROUND_BIAS = 34'sd2048;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } vec_type;

   typedef struct packed {
      vec_type low;
      vec_type high;
      logic    empty;
   } box_type;

   localparam box_type BOX_CLEAR = '{
      low:   '{x: COORD_MAX, y: COORD_MAX, z: COORD_MAX},
      high:  '{x: COORD_MIN, y: COORD_MIN, z: COORD_MIN},
      empty: 1'b1
   };

endpackage

// File: src/taabb_if.sv
// request and response channel interfaces with valid/ready handshake
// depends on taabb_pkg
`timescale 1ns / 1ps

interface taabb_req_if;
   import taabb_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [1:0]                command;
   logic signed [COORD_W-1:0] coord_x;
   logic signed [COORD_W-1:0] coord_y;
   logic signed [COORD_W-1:0] coord_z;

   modport source (output valid, command, coord_x, coord_y, coord_z, input ready);
   modport sink   (input valid, command, coord_x, coord_y, coord_z, output ready);
endinterface

interface taabb_rsp_if;
   import taabb_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [DIST_W-1:0]         squared_distance;
   logic                      box_empty;
   logic signed [COORD_W-1:0] low_x;
   logic signed [COORD_W-1:0] low_y;
   logic signed [COORD_W-1:0] low_z;
   logic signed [COORD_W-1:0] high_x;
   logic signed [COORD_W-1:0] high_y;
   logic signed [COORD_W-1:0] high_z;

   modport source (output valid, squared_distance, box_empty,
                   low_x, low_y, low_z, high_x, high_y, high_z, input ready);
   modport sink   (input valid, squared_distance, box_empty,
                   low_x, low_y, low_z, high_x, high_y, high_z, output ready);
endinterface

// File: src/taabb_xform.sv
// one row of the affine transform: q4.12 row times q8.8 vertex, rounded and saturated
// depends on taabb_pkg
`timescale 1ns / 1ps

module taabb_xform
   import taabb_pkg::*;
(
   input  logic [CSR_W-1:0]          row,
   input  vec_type                   vertex,
   output logic signed [COORD_W-1:0] result
);

   logic signed [COORD_W-1:0]   coef_x, coef_y, coef_z, coef_t;
   logic signed [SQ_W-1:0]      prod_x, prod_y, prod_z;
   logic signed [ACC_W-1:0]     acc, biased;
   logic signed [Q_W-1:0]       quot;

   assign coef_x = $signed(row[15:0]);
   assign coef_y = $signed(row[31:16]);
   assign coef_z = $signed(row[47:32]);
   assign coef_t = $signed(row[63:48]);

   assign prod_x = coef_x * vertex.x;
   assign prod_y = coef_y * vertex.y;
   assign prod_z = coef_z * vertex.z;

   // translation multiplies w = 1.0, i.e. 256 in q8.8
   assign acc = ACC_W'(prod_x) + ACC_W'(prod_y) + ACC_W'(prod_z)
              + (ACC_W'(coef_t) <<< TRANS_SHIFT);
   assign biased = acc + ROUND_BIAS;
   // arithmetic shift floors, so with the bias this rounds half up
   assign quot = Q_W'(biased >>> FRAC_SHIFT);

   always_comb begin
      if (quot > Q_W'(COORD_MAX)) begin
         result = COORD_MAX;
      end else if (quot < Q_W'(COORD_MIN)) begin
         result = COORD_MIN;
      end else begin
         result = quot[COORD_W-1:0];
      end
   end

endmodule

// File: src/taabb_dist.sv
// squared distance from a coordinate to an interval on one axis
// depends on taabb_pkg
`timescale 1ns / 1ps

module taabb_dist
   import taabb_pkg::*;
(
   input  logic signed [COORD_W-1:0] point,
   input  logic signed [COORD_W-1:0] low,
   input  logic signed [COORD_W-1:0] high,
   output logic [SQ_W-1:0]           sq
);

   logic signed [COORD_W:0] below, above;
   logic [COORD_W-1:0]      gap;

   assign below = (COORD_W+1)'(low) - (COORD_W+1)'(point);
   assign above = (COORD_W+1)'(point) - (COORD_W+1)'(high);

   // gap never exceeds 65535, so the low bits hold it unsigned
   always_comb begin
      if (point < low) begin
         gap = below[COORD_W-1:0];
      end else if (point > high) begin
         gap = above[COORD_W-1:0];
      end else begin
         gap = '0;
      end
   end

   assign sq = SQ_W'(gap) * SQ_W'(gap);

endmodule

// File: src/transformed_aabb_distance_query.sv
// top level of the transformed bounding box distance query
// depends on taabb_pkg, taabb_if, taabb_xform and taabb_dist
`timescale 1ns / 1ps

// Commands arrive on req_bus and are registered once, then handled in a single
// pass of combinational logic feeding the box registers or the response register.
// A clear command resets the box to empty; a vertex command runs the vertex
// through the 3x4 q4.12 matrix held in the three csr rows, rounds half up,
// saturates to q8.8 and widens the box; a query command yields one transfer on
// rsp_bus with the squared q18.16 distance of the untransformed point to the box
// (zero inside or when empty), the corners and the empty flag. Code 3 is dropped.
// The block takes one command per cycle unless a query is stalled; a command is
// held in the input register, and a query's response is registered as it leaves.
// A vertex updates the box in the same cycle it leaves the input register, so a
// query right behind it already sees the widened box. A response waiting on
// rsp_bus stalls only a query behind it; other commands keep flowing. Csr rows are
// written directly by csr_we and should only change while no command is in flight.

module transformed_aabb_distance_query
   import taabb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   taabb_req_if.sink                req_bus,
   taabb_rsp_if.source              rsp_bus,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_W-1:0]         csr_wdata
);

   // matrix rows
   logic [CSR_W-1:0] row_x_ff, row_y_ff, row_z_ff;

   // input register stage
   logic       s1_valid_ff, s1_valid_in;
   logic [1:0] s1_cmd_ff;
   vec_type    s1_coord_ff;

   // running box
   box_type box_ff, box_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0] rsp_dist_ff;
   box_type           rsp_box_ff;

   logic s1_is_query;
   logic rsp_free;
   logic s1_advance;
   logic req_take;

   vec_type            xf;
   logic [SQ_W-1:0]    sq_x, sq_y, sq_z;
   logic [DIST_W-1:0]  dist_sum;

   // csr writes, indexes past the last row are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         row_x_ff <= ROW_X_RESET;
         row_y_ff <= ROW_Y_RESET;
         row_z_ff <= ROW_Z_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROW_X: row_x_ff <= csr_wdata;
            CSR_ROW_Y: row_y_ff <= csr_wdata;
            CSR_ROW_Z: row_z_ff <= csr_wdata;
            default:   ;
         endcase
      end
   end

   // handshake: a query needs room in the response register, anything else moves on
   assign s1_is_query = (s1_cmd_ff == CMD_QUERY);
   assign rsp_free    = !rsp_valid_ff || rsp_bus.ready;
   assign s1_advance  = s1_valid_ff && (!s1_is_query || rsp_free);
   assign req_bus.ready = !s1_valid_ff || s1_advance;
   assign req_take    = req_bus.valid && req_bus.ready;

   assign s1_valid_in = req_take || (s1_valid_ff && !s1_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff   <= req_bus.command;
         s1_coord_ff <= '{x: req_bus.coord_x, y: req_bus.coord_y, z: req_bus.coord_z};
      end
   end

   // vertex transform, one unit per output axis
   taabb_xform u_xform_x (.row(row_x_ff), .vertex(s1_coord_ff), .result(xf.x));
   taabb_xform u_xform_y (.row(row_y_ff), .vertex(s1_coord_ff), .result(xf.y));
   taabb_xform u_xform_z (.row(row_z_ff), .vertex(s1_coord_ff), .result(xf.z));

   // box update
   always_comb begin
      box_in = box_ff;
      if (s1_advance) begin
         case (s1_cmd_ff)
            CMD_CLEAR: begin
               box_in = BOX_CLEAR;
            end
            CMD_VERTEX: begin
               if (xf.x < box_ff.low.x)  box_in.low.x  = xf.x;
               if (xf.y < box_ff.low.y)  box_in.low.y  = xf.y;
               if (xf.z < box_ff.low.z)  box_in.low.z  = xf.z;
               if (xf.x > box_ff.high.x) box_in.high.x = xf.x;
               if (xf.y > box_ff.high.y) box_in.high.y = xf.y;
               if (xf.z > box_ff.high.z) box_in.high.z = xf.z;
               box_in.empty = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff <= BOX_CLEAR;
      end else begin
         box_ff <= box_in;
      end
   end

   // query: per-axis clamped squared gaps against the current box
   taabb_dist u_dist_x (.point(s1_coord_ff.x), .low(box_ff.low.x), .high(box_ff.high.x),
                        .sq(sq_x));
   taabb_dist u_dist_y (.point(s1_coord_ff.y), .low(box_ff.low.y), .high(box_ff.high.y),
                        .sq(sq_y));
   taabb_dist u_dist_z (.point(s1_coord_ff.z), .low(box_ff.low.z), .high(box_ff.high.z),
                        .sq(sq_z));

   // empty box reports zero distance
   assign dist_sum = box_ff.empty ? '0
                   : DIST_W'(sq_x) + DIST_W'(sq_y) + DIST_W'(sq_z);

   // response register, loads on a query leaving the input stage
   assign rsp_valid_in = (s1_advance && s1_is_query) || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_is_query) begin
         rsp_dist_ff <= dist_sum;
         rsp_box_ff  <= box_ff;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.squared_distance = rsp_dist_ff;
   assign rsp_bus.box_empty        = rsp_box_ff.empty;
   assign rsp_bus.low_x            = rsp_box_ff.low.x;
   assign rsp_bus.low_y            = rsp_box_ff.low.y;
   assign rsp_bus.low_z            = rsp_box_ff.low.z;
   assign rsp_bus.high_x           = rsp_box_ff.high.x;
   assign rsp_bus.high_y           = rsp_box_ff.high.y;
   assign rsp_bus.high_z           = rsp_box_ff.high.z;

endmodule
